// ===== hdl/sobel_edge_magnitude_unit_defines.svh =====
// Assertion macros for the checker file.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
package sem_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int EDGE_W    = 14;
    localparam int GRAD_W    = 11;
    localparam int SQ_W      = 2 * GRAD_W;
    localparam int MAG_W     = 11;

    // Output scaling: edge = (mag * EDGE_SCALE) >> EDGE_SHIFT
    localparam int                    EDGE_SCALE_W = 13;
    localparam logic [EDGE_SCALE_W-1:0] EDGE_SCALE = 13'd6121;
    localparam int                    EDGE_SHIFT   = 10;
    localparam int                    EDGE_MAX     = 8626;

    // Frame geometry
    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_HEIGHT     = 2048;
    localparam int MIN_DIM            = 3;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_GRAD,
        S_SQUARE,
        S_SQRT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;   // latch pixel, read line stores
        logic update;    // shift window, write line stores, advance counters
        logic grad;      // register gx, gy
        logic sq_start;  // square, sum, start root
        logic emit;      // scale root into output register
    } t_dp_cmd;

    typedef struct packed {
        logic produce;   // current position lies inside the frame border
        logic sqrt_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/sem_pix_if.sv =====
interface sem_pix_if import sem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hdl/sem_edge_if.sv =====
interface sem_edge_if import sem_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] edge_strength;
    logic              frame_done;

    modport source (output valid, output edge_strength, output frame_done, input ready);
    modport sink   (input valid, input edge_strength, input frame_done, output ready);
endinterface

// ===== hdl/sobel_edge_magnitude_unit.sv =====
// Channel   Dir  Handshake        Payload
// i_pix     in   valid / ready    pixel[7:0]
// o_edge    out  valid / ready    edge_strength[13:0], frame_done
// cfg       in   i_cfg_we         i_cfg_idx[1:0], i_cfg_data[11:0]
//
// A border pixel passes through capture and update only; an inner pixel then goes on
// through gradient, square, the one-bit-per-cycle square root unit and emit.
// A finished item waits in the output register while the next pixel is taken;
// the emit step stalls only if that register is still occupied.
// Reset (i_rst_n low, synchronous) clears counters, window, control and output
// valid, and restores 640 x 480. Line stores need no clearing.
module sobel_edge_magnitude_unit import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    sem_pix_if.sink              i_pix,
    sem_edge_if.source           o_edge
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    sem_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sem_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pix.pixel),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_edge.ready),
        .o_out_valid     (o_edge.valid),
        .o_edge_strength (o_edge.edge_strength),
        .o_frame_done    (o_edge.frame_done)
    );

    assign i_pix.ready = in_ready;

endmodule

// ===== hdl/sem_isqrt.sv =====
module sem_isqrt import sem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_value,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] n_v;
    logic [SQ_W-1:0] n_res;
    logic [SQ_W-1:0] trial;

    // One bit of the root per cycle
    always_comb begin
        trial = r_res + r_bit;
        if (r_v >= trial) begin
            n_v   = r_v - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_v   = r_v;
            n_res = r_res >> 1;
        end
    end

    // Load on start, step until the probe bit runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (r_bit != '0) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = (r_bit == '0);
    assign o_root = r_res[MAG_W-1:0];

endmodule

// ===== hdl/sem_datapath.sv =====
module sem_datapath import sem_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [PIX_W-1:0]     i_pixel,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [EDGE_W-1:0]    o_edge_strength,
    output logic                 o_frame_done
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WDW0 = $clog2(MAX_WIDTH + 1);
    localparam int HDW0 = $clog2(MAX_HEIGHT + 1);
    localparam int WDW  = (WDW0 > CFG_W) ? WDW0 : CFG_W;
    localparam int HDW  = (HDW0 > CFG_W) ? HDW0 : CFG_W;
    localparam int PW   = MAG_W + EDGE_SCALE_W;

    logic [CFG_W-1:0]  r_frame_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [PIX_W-1:0]  r_line_a [MAX_WIDTH];
    logic [PIX_W-1:0]  r_line_b [MAX_WIDTH];
    logic [PIX_W-1:0]  r_px;
    logic [PIX_W-1:0]  r_top;
    logic [PIX_W-1:0]  r_mid;
    logic [PIX_W-1:0]  r_win [9];
    logic              r_last;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic              r_out_valid;
    logic [EDGE_W-1:0] r_edge;
    logic              r_done;

    logic [WDW-1:0]    w_ext;
    logic [WDW-1:0]    eff_w;
    logic [WDW-1:0]    col_next;
    logic              col_last;
    logic [HDW-1:0]    h_ext;
    logic [HDW-1:0]    eff_h;
    logic [HDW-1:0]    row_next;
    logic              row_last;
    logic [GRAD_W-2:0] sum_t;
    logic [GRAD_W-2:0] sum_b;
    logic [GRAD_W-2:0] sum_l;
    logic [GRAD_W-2:0] sum_r;
    logic signed [SQ_W-1:0] gx2;
    logic signed [SQ_W-1:0] gy2;
    logic [SQ_W-1:0]   sq;
    logic              sqrt_done;
    logic [MAG_W-1:0]  root;
    logic [PW-1:0]     prod;

    // Clamp the frame size and find row and column ends
    always_comb begin
        w_ext = WDW'(r_frame_width);
        if (w_ext < WDW'(MIN_DIM)) begin
            eff_w = WDW'(MIN_DIM);
        end else if (w_ext > WDW'(MAX_WIDTH)) begin
            eff_w = WDW'(MAX_WIDTH);
        end else begin
            eff_w = w_ext;
        end
        h_ext = HDW'(r_frame_height);
        if (h_ext < HDW'(MIN_DIM)) begin
            eff_h = HDW'(MIN_DIM);
        end else if (h_ext > HDW'(MAX_HEIGHT)) begin
            eff_h = HDW'(MAX_HEIGHT);
        end else begin
            eff_h = h_ext;
        end
        col_next = WDW'(r_col) + WDW'(1);
        row_next = HDW'(r_row) + HDW'(1);
        col_last = (col_next >= eff_w);
        row_last = (row_next >= eff_h);
    end

    // Configuration and position counters; a width or height write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_FRAME_WIDTH)) begin
            r_frame_width <= i_cfg_data;
            r_col         <= '0;
            r_row         <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_FRAME_HEIGHT)) begin
            r_frame_height <= i_cfg_data;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cmd.update) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : row_next[RW-1:0];
            end else begin
                r_col <= col_next[CW-1:0];
            end
        end
    end

    // Line store for the row above
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mid <= r_line_a[r_col];
        end
        if (i_cmd.update) begin
            r_line_a[r_col] <= r_px;
        end
    end

    // Line store for the row two above
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top <= r_line_b[r_col];
        end
        if (i_cmd.update) begin
            r_line_b[r_col] <= r_mid;
        end
    end

    // Hold the accepted pixel and the end-of-frame flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_pixel;
        end
        if (i_cmd.update) begin
            r_last <= col_last && row_last;
        end
    end

    // Shift the window one column left, newest column on the right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= r_top;
            r_win[5] <= r_mid;
            r_win[8] <= r_px;
        end
    end

    // Kernel sums: top, bottom, left and right edges of the window
    always_comb begin
        sum_t = (GRAD_W-1)'(r_win[0]) + ((GRAD_W-1)'(r_win[1]) << 1) + (GRAD_W-1)'(r_win[2]);
        sum_b = (GRAD_W-1)'(r_win[6]) + ((GRAD_W-1)'(r_win[7]) << 1) + (GRAD_W-1)'(r_win[8]);
        sum_l = (GRAD_W-1)'(r_win[0]) + ((GRAD_W-1)'(r_win[3]) << 1) + (GRAD_W-1)'(r_win[6]);
        sum_r = (GRAD_W-1)'(r_win[2]) + ((GRAD_W-1)'(r_win[5]) << 1) + (GRAD_W-1)'(r_win[8]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
            r_gy <= $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
        end
    end

    // Sum of squares feeds the root unit directly
    always_comb begin
        gx2 = r_gx * r_gx;
        gy2 = r_gy * r_gy;
        sq  = $unsigned(gx2) + $unsigned(gy2);
    end

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_value (sq),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    // Scale the root and load the output register
    assign prod = PW'(root) * PW'(EDGE_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_edge <= prod[EDGE_SHIFT +: EDGE_W];
            r_done <= r_last;
        end
    end

    assign o_status.produce   = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign o_status.sqrt_done = sqrt_done;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_edge_strength = r_edge;
    assign o_frame_done    = r_done;

endmodule

// ===== hdl/sem_controller.sv =====
module sem_controller import sem_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = i_status.produce ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
                n_state = S_SQUARE;
            end
            S_SQUARE: begin
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_status.sqrt_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_GRAD: begin
                o_cmd.grad = 1'b1;
            end
            S_SQUARE: begin
                o_cmd.sq_start = 1'b1;
            end
            S_SQRT: begin
                o_cmd = '0;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/sem_checker.sv =====
`include "sobel_edge_magnitude_unit_defines.svh"

module sem_checker import sem_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [EDGE_W-1:0] i_edge_strength
);

    // A stalled result holds its value
    `SEM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_edge_strength), "stalled item changed")

    // Normalized magnitude stays in range
    `SEM_ASSERT_NOW(a_edge_range, i_clk, i_rst_n, i_out_valid, i_edge_strength <= EDGE_W'(EDGE_MAX), "edge strength out of range")

    // One pixel at a time: input closes right after an accept
    `SEM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "pixel taken in back-to-back cycles")

    // A new result never follows an accept directly
    `SEM_ASSERT_NOW(a_no_instant_result, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_valid && i_in_ready), "result right after accept")

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_edge.valid),
    .i_out_ready     (o_edge.ready),
    .i_edge_strength (o_edge.edge_strength)
);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int IDLE_PCT       = 27;
    localparam int RANDOM_ITEMS   = 200;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int MAX_FRAME_PX   = 150;
    localparam int PROBE_PIXELS   = 30;

    // Register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_3 = 2'd3;

    // 3x3 frames: strongest vertical gradient, strongest negative horizontal
    // gradient, and the window with the largest magnitude overall
    localparam logic [PIX_W-1:0] GRADIENT_FRAMES [27] = '{
        8'd255, 8'd255, 8'd255,   8'd0,   8'd0,   8'd0,   8'd0,  8'd0,   8'd0,
        8'd0,   8'd90,  8'd255,   8'd0,   8'd90,  8'd255, 8'd0,  8'd90,  8'd255,
        8'd255, 8'd255, 8'd255,   8'd255, 8'd77,  8'd0,   8'd0,  8'd0,   8'd0
    };

    typedef enum logic [1:0] {
        PAT_UNIFORM,
        PAT_EXTREME,
        PAT_SMOOTH,
        PAT_FLAT
    } t_pixel_pattern;

    typedef struct packed {
        logic [EDGE_W-1:0] strength;
        logic              done;
    } t_edge_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    sem_pix_if  pix_if ();
    sem_edge_if edge_if ();

    sobel_edge_magnitude_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_edge     (edge_if)
    );

    // Predicted block state
    logic [CFG_W-1:0] geo_width_reg;
    logic [CFG_W-1:0] geo_height_reg;
    bit   [PIX_W-1:0] line_r1 [DEF_MAX_WIDTH];
    bit   [PIX_W-1:0] line_r2 [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int unsigned      col_pos;
    int unsigned      row_pos;

    t_edge_item  expected_edges [$];
    int unsigned fail_count;
    int unsigned pix_sent;
    int unsigned quiet_cycles;
    int unsigned sink_hold_req;
    int unsigned sink_hold_left;
    bit          steady;

    // Geometry as last programmed by the stimulus
    logic [CFG_W-1:0] prog_width  = FRAME_WIDTH_RESET;
    logic [CFG_W-1:0] prog_height = FRAME_HEIGHT_RESET;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned effective_dim(input logic [CFG_W-1:0] raw,
                                                  input int unsigned hi);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > hi) return hi;
        return raw;
    endfunction

    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = 11; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // Shift the window, update line stores and position, return the edge item, if any
    task automatic compute_edge_item(input logic [PIX_W-1:0] px, output bit produced,
                                     output t_edge_item item);
        int unsigned w, h, ci, mag, scaled;
        int          gx, gy, k;
        w  = effective_dim(geo_width_reg, DEF_MAX_WIDTH);
        h  = effective_dim(geo_height_reg, DEF_MAX_HEIGHT);
        ci = col_pos % DEF_MAX_WIDTH;
        for (k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = line_r2[ci];
        win[5] = line_r1[ci];
        win[8] = px;
        line_r2[ci] = line_r1[ci];
        line_r1[ci] = px;

        produced = (row_pos >= 2) && (col_pos >= 2);
        item = '0;
        if (produced) begin
            gx = (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]))
               - (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]));
            gy = (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]))
               - (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]));
            mag    = floor_sqrt(gx * gx + gy * gy);
            scaled = (mag * EDGE_SCALE) >> EDGE_SHIFT;
            item.strength = scaled[EDGE_W-1:0];
            item.done     = (row_pos + 1 >= h) && (col_pos + 1 >= w);
        end

        // Advance raster position, wrap at end of row and frame
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
        if (idx == CFG_FRAME_WIDTH) begin
            geo_width_reg = data;
        end else if (idx == CFG_FRAME_HEIGHT) begin
            geo_height_reg = data;
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Check each result against the oldest expectation, then predict from new items
    always @(posedge i_clk) begin
        t_edge_item got;
        t_edge_item want;
        bit         made;
        if (!i_rst_n) begin
            geo_width_reg  = FRAME_WIDTH_RESET;
            geo_height_reg = FRAME_HEIGHT_RESET;
            foreach (win[k]) win[k] = '0;
            col_pos = 0;
            row_pos = 0;
        end else begin
            if (edge_if.valid && edge_if.ready) begin
                got = '{edge_if.edge_strength, edge_if.frame_done};
                if (expected_edges.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected edge item: strength %0d, frame_done %0b",
                                 $realtime, got.strength, got.done);
                end else begin
                    want = expected_edges.pop_front();
                    if (got.strength !== want.strength)
                        note_mismatch("edge_strength", want.strength, got.strength);
                    if (got.done !== want.done)
                        note_mismatch("frame_done", want.done, got.done);
                end
            end
            if (i_cfg_we)
                apply_reg_write(i_cfg_idx, i_cfg_data);
            if (pix_if.valid && pix_if.ready) begin
                compute_edge_item(pix_if.pixel, made, want);
                if (made) expected_edges.push_back(want);
            end
        end
    end

    // Receiver: random stalls, optional long hold-off counted here
    always @(posedge i_clk) begin
        if (sink_hold_req != 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (!i_rst_n) begin
            edge_if.ready <= 1'b0;
        end else if (sink_hold_left != 0) begin
            sink_hold_left = sink_hold_left - 1;
            edge_if.ready <= 1'b0;
        end else begin
            edge_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (pix_if.valid && pix_if.ready)
            || (edge_if.valid && edge_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input t_pixel_pattern pat,
                                                    input logic [PIX_W-1:0] base);
        case (pat)
            PAT_EXTREME: return $urandom_range(1) ? '1 : '0;
            PAT_SMOOTH:  return base + PIX_W'($urandom_range(6));
            PAT_FLAT:    return base;
            default:     return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6) return CFG_W'($urandom_range(MIN_DIM - 1));
        if (roll < 80) return CFG_W'($urandom_range(12, MIN_DIM));
        return CFG_W'($urandom_range(70, 13));
    endfunction

    // Offer one item, idling at random first; hold valid high after acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pix_sent++;
    endtask

    task automatic send_pixels(input int unsigned count, input t_pixel_pattern pat,
                               input logic [PIX_W-1:0] base);
        int unsigned i;
        for (i = 0; i < count; i++) send_pixel(pick_pixel(pat, base));
    endtask

    // Drop valid, wait for every expected item, then let the block settle
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_FRAME_WIDTH) prog_width = data;
        else if (idx == CFG_FRAME_HEIGHT) prog_height = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FRAME_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FRAME_HEIGHT;
        i_cfg_data <= height;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        prog_width  = width;
        prog_height = height;
    endtask

    function automatic int unsigned frame_pixels(input logic [CFG_W-1:0] width,
                                                 input logic [CFG_W-1:0] height);
        return effective_dim(width, DEF_MAX_WIDTH) * effective_dim(height, DEF_MAX_HEIGHT);
    endfunction

    // Reset geometry: two full rows plus ten pixels into the third; first row
    // goes without any idling on either side
    task automatic test_default_geometry();
        steady = 1'b1;
        send_pixels(effective_dim(prog_width, DEF_MAX_WIDTH), PAT_UNIFORM, '0);
        steady = 1'b0;
        send_pixels(effective_dim(prog_width, DEF_MAX_WIDTH) + 10, PAT_UNIFORM, '0);
        wait_drained();
    endtask

    // Minimum frame (both registers below range): strongest vertical, strongest negative horizontal, largest magnitude
    task automatic test_gradient_extremes();
        int i;
        set_geometry('0, CFG_W'(MIN_DIM - 1));
        for (i = 0; i < 27; i++) send_pixel(GRADIENT_FRAMES[i]);
        wait_drained();
    endtask

    // Writes past the register list must neither change geometry nor restart the frame
    task automatic test_unused_index();
        set_geometry(CFG_W'(4), CFG_W'(4));
        send_pixels(6, PAT_FLAT, 8'd200);
        wait_drained();
        write_reg(CFG_NONE_2, '1);
        send_pixels(5, PAT_FLAT, 8'd200);
        wait_drained();
        write_reg(CFG_NONE_3, '0);
        send_pixels(5 + frame_pixels(prog_width, prog_height), PAT_UNIFORM, '0);
        wait_drained();
    endtask

    // Hold the receiver off while items keep coming so the input stalls
    task automatic test_output_backpressure();
        set_geometry(CFG_W'(6), CFG_W'(5));
        sink_hold_req = HOLD_CYCLES;
        send_pixels(3 * frame_pixels(prog_width, prog_height), PAT_UNIFORM, '0);
        wait_drained();
    endtask

    // Random geometry, content and frame counts, with partial frames cut by a write
    task automatic test_random_frames();
        int unsigned    first, frame_px, extra, roll;
        logic [CFG_W-1:0] w_raw, h_raw;
        t_pixel_pattern pat;
        first = pix_sent;
        while (pix_sent - first < RANDOM_ITEMS) begin
            w_raw = pick_dim();
            h_raw = pick_dim();
            if (frame_pixels(w_raw, h_raw) > MAX_FRAME_PX)
                h_raw = CFG_W'($urandom_range(5, MIN_DIM));
            if (frame_pixels(w_raw, h_raw) > MAX_FRAME_PX)
                w_raw = CFG_W'($urandom_range(12, MIN_DIM));
            roll = $urandom_range(9);
            if (roll == 0 && frame_pixels(w_raw, prog_height) <= MAX_FRAME_PX) begin
                write_reg(CFG_FRAME_WIDTH, w_raw);
            end else if (roll == 1 && frame_pixels(prog_width, h_raw) <= MAX_FRAME_PX) begin
                write_reg(CFG_FRAME_HEIGHT, h_raw);
            end else begin
                set_geometry(w_raw, h_raw);
            end
            frame_px = frame_pixels(prog_width, prog_height);
            extra = ($urandom_range(99) < 15) ? $urandom_range(frame_px - 1, 1) : 0;
            pat = t_pixel_pattern'($urandom_range(3));
            send_pixels($urandom_range(3, 1) * frame_px + extra, pat,
                        PIX_W'($urandom_range(249)));
            wait_drained();
        end
    endtask

    // Width above range, height below; then width below, height at the limit: the start of
    // each frame must follow the clamped size, with no early row wrap and no early frame end
    task automatic test_max_geometry();
        set_geometry('1, '0);
        send_pixels(PROBE_PIXELS, PAT_UNIFORM, '0);
        wait_drained();
        set_geometry(CFG_W'(1), CFG_W'(DEF_MAX_HEIGHT));
        send_pixels(PROBE_PIXELS, PAT_UNIFORM, '0);
        wait_drained();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        pix_if.valid  <= 1'b0;
        pix_if.pixel  <= '0;
        fail_count    = 0;
        pix_sent      = 0;
        sink_hold_req = 0;
        steady        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_geometry();
        test_gradient_extremes();
        test_unused_index();
        test_output_backpressure();
        test_random_frames();
        test_max_geometry();

        wait_drained();
        if (fail_count == 0 && expected_edges.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_pix_if.sv
hdl/sem_edge_if.sv
hdl/sem_isqrt.sv
hdl/sem_datapath.sv
hdl/sem_controller.sv
hdl/sobel_edge_magnitude_unit.sv
hdl/sem_checker.sv
tb/testbench.sv
